/* src/apm_pkg.sv */
// apm_pkg: shared types and constants for the autoscale plot point mapper
// register map, config field widths and reset values, state enums
// no dependencies
`default_nettype none

package apm_pkg;

    // config register fields
    localparam int CFG_W     = 12;
    localparam int PAD_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] PLOT_WIDTH_RST   = 12'd256;
    localparam logic [CFG_W-1:0] PLOT_HEIGHT_RST  = 12'd128;
    localparam logic [PAD_W-1:0] EDGE_PADDING_RST = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLOT_WIDTH   = 2'd0,
        REG_PLOT_HEIGHT  = 2'd1,
        REG_EDGE_PADDING = 2'd2
    } cfg_reg_t;

    // point queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        FRONT_LOAD,
        FRONT_SCAN
    } front_state_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_MUL,
        BACK_SUB,
        BACK_DIVX,
        BACK_YSTART,
        BACK_DIVY,
        BACK_DONE
    } back_state_t;

endpackage

`default_nettype wire

/* src/autoscale_plot_point_mapper_core.sv */
// samples load at one per cycle; an end_of_set item with valid samples drops s_ready
// while the slots are scanned, until every slot is read and each valid point enters the queue
// each point goes through the shared bit-serial divider, which produces x and then y
// synchronous active-low reset clears counters, min/max, queue and output valid
`default_nettype none

module autoscale_plot_point_mapper_core #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample_value,
    input  logic                              s_sample_valid,
    input  logic                              s_end_of_set,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [COORD_BITS-1:0]             m_point_x,
    output logic [COORD_BITS-1:0]             m_point_y,
    output logic                              m_last_point,
    input  logic                              cfg_wr_en,
    input  logic [apm_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [apm_pkg::CFG_W-1:0]         cfg_wr_data
);
    import apm_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int JOB_W = 3 * SAMPLE_BITS + 2 * IDX_W + 1;

    logic [CFG_W-1:0] plot_width_reg, plot_height_reg;
    logic [PAD_W-1:0] edge_padding_reg;

    logic                          f_valid, f_ready, f_last;
    logic signed [SAMPLE_BITS-1:0] f_sample, f_lo;
    logic [SAMPLE_BITS-1:0]        f_d;
    logic [IDX_W-1:0]              f_idx, f_nm1;

    logic                          b_valid, b_ready, b_last;
    logic signed [SAMPLE_BITS-1:0] b_sample, b_lo;
    logic [SAMPLE_BITS-1:0]        b_d;
    logic [IDX_W-1:0]              b_idx, b_nm1;

    logic [JOB_W-1:0]              q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plot_width_reg   <= PLOT_WIDTH_RST;
            plot_height_reg  <= PLOT_HEIGHT_RST;
            edge_padding_reg <= EDGE_PADDING_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_PLOT_WIDTH:   plot_width_reg   <= cfg_wr_data;
                REG_PLOT_HEIGHT:  plot_height_reg  <= cfg_wr_data;
                REG_EDGE_PADDING: edge_padding_reg <= cfg_wr_data[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    apm_front #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_sample_valid (s_sample_valid),
        .s_end_of_set   (s_end_of_set),
        .job_valid      (f_valid),
        .job_ready      (f_ready),
        .job_sample     (f_sample),
        .job_idx        (f_idx),
        .job_last       (f_last),
        .job_lo         (f_lo),
        .job_d          (f_d),
        .job_nm1        (f_nm1)
    );

    // each point carries its set's scaling so the front can start the next set
    assign q_in = {f_sample, f_idx, f_last, f_lo, f_d, f_nm1};
    assign {b_sample, b_idx, b_last, b_lo, b_d, b_nm1} = q_out;

    apm_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (q_out)
    );

    apm_back #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (b_valid),
        .job_ready    (b_ready),
        .job_sample   (b_sample),
        .job_idx      (b_idx),
        .job_last     (b_last),
        .job_lo       (b_lo),
        .job_d        (b_d),
        .job_nm1      (b_nm1),
        .plot_width   (plot_width_reg),
        .plot_height  (plot_height_reg),
        .edge_padding (edge_padding_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_last_point (m_last_point)
    );

endmodule

`default_nettype wire

/* src/apm_front.sv */
// apm_front: sample loader with min/max tracking and the slot scanner
// stores the set in a local memory, then walks the slots and pushes valid points
// depends on apm_pkg
`default_nettype none

module apm_front #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_value,
    input  logic                                  s_sample_valid,
    input  logic                                  s_end_of_set,
    output logic                                  job_valid,
    input  logic                                  job_ready,
    output logic signed [SAMPLE_BITS-1:0]         job_sample,
    output logic [$clog2(MAX_POINTS)-1:0]         job_idx,
    output logic                                  job_last,
    output logic signed [SAMPLE_BITS-1:0]         job_lo,
    output logic [SAMPLE_BITS-1:0]                job_d,
    output logic [$clog2(MAX_POINTS)-1:0]         job_nm1
);
    import apm_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic signed [SAMPLE_BITS-1:0] SMP_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    front_state_t state_reg, state_next;

    logic [CNT_W-1:0]              slot_cnt_reg, scan_cnt_reg, scan_n_reg, n_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, max_reg, min_next, max_next, set_lo_reg;
    logic [SAMPLE_BITS-1:0]        set_d_reg;
    logic [IDX_W-1:0]              set_nm1_reg, set_last_reg, rd_idx_reg;
    logic [IDX_W-1:0]              last_valid_reg, last_valid_next;
    logic                          any_reg, any_next, rd_pend_reg;
    logic                          accept, store_en, valid_in, eos_go;
    logic                          issue, rd_pop, scan_done, flat;
    logic signed [SAMPLE_BITS:0]   span;

    // slot memory: sample with its valid flag on top
    logic [SAMPLE_BITS:0] mem [MAX_POINTS];
    logic [SAMPLE_BITS:0] rd_word_reg;

    assign accept    = s_valid && s_ready;
    assign store_en  = accept && (slot_cnt_reg < CNT_W'(MAX_POINTS));
    assign valid_in  = store_en && s_sample_valid;
    assign min_next  = (valid_in && (s_sample_value < min_reg)) ? s_sample_value : min_reg;
    assign max_next  = (valid_in && (s_sample_value > max_reg)) ? s_sample_value : max_reg;
    assign any_next  = any_reg || valid_in;
    assign n_next    = store_en ? slot_cnt_reg + CNT_W'(1) : slot_cnt_reg;
    assign last_valid_next = valid_in ? slot_cnt_reg[IDX_W-1:0] : last_valid_reg;
    assign flat      = (min_next == max_next);
    assign span      = $signed({max_next[SAMPLE_BITS-1], max_next})
                     - $signed({min_next[SAMPLE_BITS-1], min_next});
    assign eos_go    = accept && s_end_of_set && any_next;

    assign scan_done = (scan_cnt_reg == scan_n_reg);
    // invalid slots drop out of the read stage without needing queue space
    assign rd_pop    = rd_pend_reg && (!rd_word_reg[SAMPLE_BITS] || job_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FRONT_LOAD: begin
                if (eos_go) begin
                    state_next = FRONT_SCAN;
                end
            end
            FRONT_SCAN: begin
                if (scan_done && (!rd_pend_reg || rd_pop)) begin
                    state_next = FRONT_LOAD;
                end
            end
            default: state_next = FRONT_LOAD;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == FRONT_LOAD);
        issue     = (state_reg == FRONT_SCAN) && !scan_done && (!rd_pend_reg || rd_pop);
        job_valid = rd_pend_reg && rd_word_reg[SAMPLE_BITS];
    end

    assign job_sample = rd_word_reg[SAMPLE_BITS-1:0];
    assign job_idx    = rd_idx_reg;
    assign job_last   = (rd_idx_reg == set_last_reg);
    assign job_lo     = set_lo_reg;
    assign job_d      = set_d_reg;
    assign job_nm1    = set_nm1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FRONT_LOAD;
            slot_cnt_reg <= '0;
            min_reg      <= SMP_TOP;
            max_reg      <= SMP_BOT;
            any_reg      <= 1'b0;
            rd_pend_reg  <= 1'b0;
            scan_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (issue) begin
                rd_pend_reg <= 1'b1;
            end else if (rd_pop) begin
                rd_pend_reg <= 1'b0;
            end
            if (accept) begin
                if (s_end_of_set) begin
                    slot_cnt_reg <= '0;
                    min_reg      <= SMP_TOP;
                    max_reg      <= SMP_BOT;
                    any_reg      <= 1'b0;
                end else begin
                    slot_cnt_reg <= n_next;
                    min_reg      <= min_next;
                    max_reg      <= max_next;
                    any_reg      <= any_next;
                end
            end
            if (eos_go) begin
                scan_cnt_reg <= '0;
            end else if (issue) begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_valid_reg <= last_valid_next;
        end
        if (eos_go) begin
            // flat set scales as range 0 to 1
            set_lo_reg   <= flat ? '0 : min_next;
            set_d_reg    <= flat ? SAMPLE_BITS'(1) : span[SAMPLE_BITS-1:0];
            set_nm1_reg  <= IDX_W'(n_next - CNT_W'(1));
            set_last_reg <= last_valid_next;
            scan_n_reg   <= n_next;
        end
        if (issue) begin
            rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            mem[slot_cnt_reg[IDX_W-1:0]] <= {s_sample_valid, s_sample_value};
        end
        if (issue) begin
            rd_word_reg <= mem[scan_cnt_reg[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

/* src/apm_queue.sv */
// apm_queue: short point queue between the scanner and the coordinate unit
// valid/ready on both sides, depth from apm_pkg
// depends on apm_pkg
`default_nettype none

module apm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import apm_pkg::*;

    logic [WIDTH-1:0]  buf_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              push, pop;

    assign in_ready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = buf_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

/* src/apm_div.sv */
// apm_div: restoring unsigned divider, one quotient bit per cycle
// divisor is latched at start, done pulses when the quotient is ready
// no package dependencies
`default_nettype none

module apm_div #(
    parameter int DVD_W = 30,
    parameter int DVS_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg, dvs_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   trial, trial_sub;
    logic             fits;

    // dividend bits shift out of the top as quotient bits shift in
    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

/* src/apm_back.sv */
// apm_back: per-point coordinate unit and output register
// products, numerator, then x and y quotients through one shared divider
// depends on apm_pkg and apm_div
`default_nettype none

module apm_back #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  job_valid,
    output logic                                  job_ready,
    input  logic signed [SAMPLE_BITS-1:0]         job_sample,
    input  logic [$clog2(MAX_POINTS)-1:0]         job_idx,
    input  logic                                  job_last,
    input  logic signed [SAMPLE_BITS-1:0]         job_lo,
    input  logic [SAMPLE_BITS-1:0]                job_d,
    input  logic [$clog2(MAX_POINTS)-1:0]         job_nm1,
    input  logic [apm_pkg::CFG_W-1:0]             plot_width,
    input  logic [apm_pkg::CFG_W-1:0]             plot_height,
    input  logic [apm_pkg::PAD_W-1:0]             edge_padding,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [COORD_BITS-1:0]                 m_point_x,
    output logic [COORD_BITS-1:0]                 m_point_y,
    output logic                                  m_last_point
);
    import apm_pkg::*;

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int PROD_W    = CFG_W + SAMPLE_BITS + 2;
    localparam int NUM_W     = PROD_W + 1;
    localparam int DVD_W     = NUM_W - 1;
    localparam int XW        = (CFG_W + 1 > COORD_BITS) ? CFG_W + 1 : COORD_BITS;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    back_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] smp_reg, lo_reg;
    logic [SAMPLE_BITS-1:0]        d_reg;
    logic [IDX_W-1:0]              idx_reg, nm1_reg;
    logic                          last_reg;
    logic [CFG_W+IDX_W-1:0]        xprod_reg;
    logic signed [PROD_W-1:0]      ya_reg, yb_reg;
    logic signed [NUM_W-1:0]       num_reg;
    logic [CFG_W:0]                x_raw_reg;
    logic [COORD_BITS-1:0]         y_reg;

    logic                          m_valid_reg, m_last_reg;
    logic [COORD_BITS-1:0]         m_x_reg, m_y_reg;

    logic [PAD_W:0]                pad2;
    logic [CFG_W-1:0]              span_w, span_h;
    logic signed [CFG_W:0]         hp;
    logic signed [SAMPLE_BITS:0]   diff;
    logic [XW-1:0]                 x_ext;
    logic [COORD_BITS-1:0]         x_clamp;

    logic                          div_start, div_done, out_load;
    logic [DVD_W-1:0]              div_dividend, div_quo;
    logic [SAMPLE_BITS-1:0]        div_divisor;

    // spans below zero saturate to 0
    assign pad2   = {edge_padding, 1'b0};
    assign span_w = (plot_width > CFG_W'(pad2)) ? plot_width - CFG_W'(pad2) : '0;
    assign span_h = (plot_height > CFG_W'(pad2)) ? plot_height - CFG_W'(pad2) : '0;
    assign hp     = $signed({1'b0, plot_height})
                  - $signed({{(CFG_W + 1 - PAD_W){1'b0}}, edge_padding});
    assign diff   = $signed({smp_reg[SAMPLE_BITS-1], smp_reg})
                  - $signed({lo_reg[SAMPLE_BITS-1], lo_reg});

    assign x_ext   = XW'(x_raw_reg);
    assign x_clamp = (x_ext > XW'(COORD_MAX)) ? '1 : x_ext[COORD_BITS-1:0];

    assign div_dividend = (state_reg == BACK_SUB) ? DVD_W'(xprod_reg) : num_reg[DVD_W-1:0];
    assign div_divisor  = (state_reg == BACK_SUB) ? SAMPLE_BITS'(nm1_reg) : d_reg;

    apm_div #(
        .DVD_W (DVD_W),
        .DVS_W (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BACK_IDLE: begin
                if (job_valid) begin
                    state_next = BACK_MUL;
                end
            end
            BACK_MUL: state_next = BACK_SUB;
            BACK_SUB: begin
                state_next = (nm1_reg != '0) ? BACK_DIVX : BACK_YSTART;
            end
            BACK_DIVX: begin
                if (div_done) begin
                    state_next = BACK_YSTART;
                end
            end
            BACK_YSTART: begin
                state_next = num_reg[NUM_W-1] ? BACK_DONE : BACK_DIVY;
            end
            BACK_DIVY: begin
                if (div_done) begin
                    state_next = BACK_DONE;
                end
            end
            BACK_DONE: begin
                if (out_load) begin
                    state_next = BACK_IDLE;
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_comb begin
        job_ready = (state_reg == BACK_IDLE);
        out_load  = (state_reg == BACK_DONE) && (!m_valid_reg || m_ready);
        div_start = ((state_reg == BACK_SUB) && (nm1_reg != '0))
                 || ((state_reg == BACK_YSTART) && !num_reg[NUM_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BACK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == BACK_IDLE) && job_valid) begin
            smp_reg  <= job_sample;
            idx_reg  <= job_idx;
            last_reg <= job_last;
            lo_reg   <= job_lo;
            d_reg    <= job_d;
            nm1_reg  <= job_nm1;
        end
        if (state_reg == BACK_MUL) begin
            xprod_reg <= (CFG_W+IDX_W)'(span_w) * (CFG_W+IDX_W)'(idx_reg);
            ya_reg    <= hp * $signed({1'b0, d_reg});
            yb_reg    <= $signed({1'b0, span_h}) * diff;
        end
        if (state_reg == BACK_SUB) begin
            num_reg <= $signed({ya_reg[PROD_W-1], ya_reg})
                     - $signed({yb_reg[PROD_W-1], yb_reg});
            // one-slot set puts x at the padding
            if (nm1_reg == '0) begin
                x_raw_reg <= (CFG_W+1)'(edge_padding);
            end
        end
        if ((state_reg == BACK_DIVX) && div_done) begin
            x_raw_reg <= (CFG_W+1)'(edge_padding) + {1'b0, div_quo[CFG_W-1:0]};
        end
        if ((state_reg == BACK_YSTART) && num_reg[NUM_W-1]) begin
            y_reg <= '0;
        end
        if ((state_reg == BACK_DIVY) && div_done) begin
            y_reg <= (|div_quo[DVD_W-1:COORD_BITS]) ? '1 : div_quo[COORD_BITS-1:0];
        end
        if (out_load) begin
            m_x_reg    <= x_clamp;
            m_y_reg    <= y_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_point_x    = m_x_reg;
    assign m_point_y    = m_y_reg;
    assign m_last_point = m_last_reg;

endmodule

`default_nettype wire

/* src/apm_checker.sv */
// apm_checker: port-level checks for the plot point mapper, bound to the top level
// watches the input stall after a closing item, point order within a run and held stalled points
// depends on autoscale_plot_point_mapper_core
`default_nettype none

module apm_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  s_end_of_set,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COORD_BITS-1:0] m_point_x,
    input logic [COORD_BITS-1:0] m_point_y,
    input logic                  m_last_point
);
    logic                  in_run_reg;
    logic [COORD_BITS-1:0] prev_x_reg;
    logic                  out_acc;

    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg <= 1'b0;
        end else if (out_acc) begin
            in_run_reg <= !m_last_point;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_acc) begin
            prev_x_reg <= m_point_x;
        end
    end

    // input only stalls after a closing item
    a_stall_after_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_end_of_set))
        else $error("s_ready dropped without an accepted end_of_set item");

    // x walks left to right within one run
    a_x_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && in_run_reg) |-> (m_point_x >= prev_x_reg))
        else $error("point_x went backwards within a run");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_point_x) && $stable(m_point_y) && $stable(m_last_point)))
        else $error("stalled point changed or was dropped");

endmodule

bind autoscale_plot_point_mapper_core apm_checker #(
    .COORD_BITS (COORD_BITS)
) u_apm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_end_of_set (s_end_of_set),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_point_x    (m_point_x),
    .m_point_y    (m_point_y),
    .m_last_point (m_last_point)
);

`default_nettype wire

/* sim/tb_autoscale_plot_point_mapper_core.sv */
// tb_autoscale_plot_point_mapper_core: self-checking bench for the plot point mapper core
// predicts every point run from the stored set, its min/max and the register settings
// depends on apm_pkg and autoscale_plot_point_mapper_core
module tb_autoscale_plot_point_mapper_core;
    timeunit 1ns;
    timeprecision 1ps;

    import apm_pkg::*;

    localparam int     SLOTS         = 64;
    localparam int     SMP_W         = 16;
    localparam int     PIX_W         = 12;
    localparam longint PIX_MAX       = (64'd1 << PIX_W) - 1;
    localparam longint SMP_TOP       = (64'd1 << (SMP_W - 1)) - 1;
    localparam longint SMP_BOT       = -SMP_TOP - 1;
    localparam int     STALL_LIMIT   = 20000;
    localparam int     LONG_HOLD     = 3000;
    localparam int     SETTLE_CYCLES = 300;
    localparam int     PHASE_ITEMS   = 58;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic signed [SMP_W-1:0] value;
        logic                    ok;
        logic                    eos;
    } sample_item_t;

    typedef struct {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             last;
    } point_t;

    typedef enum {SET_WIDE, SET_NARROW, SET_FLAT, SET_BLANK} set_kind_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic signed [SMP_W-1:0] s_sample_value = '0;
    logic                    s_sample_valid = 1'b0;
    logic                    s_end_of_set   = 1'b0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [PIX_W-1:0]        m_point_x;
    logic [PIX_W-1:0]        m_point_y;
    logic                    m_last_point;
    logic                    cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_wr_index   = '0;
    logic [CFG_W-1:0]        cfg_wr_data    = '0;

    autoscale_plot_point_mapper_core #(
        .MAX_POINTS (SLOTS),
        .SAMPLE_BITS(SMP_W),
        .COORD_BITS (PIX_W)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_value(s_sample_value),
        .s_sample_valid(s_sample_valid),
        .s_end_of_set  (s_end_of_set),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_last_point  (m_last_point),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: current set and register copies
    logic signed [SMP_W-1:0] held_value [SLOTS];
    bit                      held_ok    [SLOTS];
    int                      held_count;
    longint                  run_min;
    longint                  run_max;
    bit                      seen_valid;
    longint                  cur_width;
    longint                  cur_height;
    longint                  cur_pad;

    sample_item_t pending_q[$];
    point_t       point_q[$];
    int unsigned  items_queued;
    int unsigned  items_taken;
    int unsigned  points_seen;
    int unsigned  mismatches;
    int unsigned  holds_asked;
    int unsigned  holds_done;

    function automatic logic [PIX_W-1:0] to_pixel(input longint c);
        if (c < 0) return '0;
        if (c > PIX_MAX) return '1;
        return PIX_W'(c);
    endfunction

    task automatic restart_set();
        held_count = 0;
        run_min    = SMP_TOP;
        run_max    = SMP_BOT;
        seen_valid = 1'b0;
    endtask

    // store one accepted item; on the closing item queue the whole point run
    task automatic map_item(input logic signed [SMP_W-1:0] value, input logic ok,
                            input logic eos);
        longint lo, hi, span_d, span_w, span_h, x, y, num;
        int     last_slot;
        point_t pt;
        if (held_count < SLOTS) begin
            held_value[held_count] = value;
            held_ok[held_count]    = ok;
            held_count++;
            if (ok) begin
                if (value < run_min) run_min = value;
                if (value > run_max) run_max = value;
                seen_valid = 1'b1;
            end
        end
        if (!eos) return;
        if (!seen_valid) begin
            restart_set();
            return;
        end
        lo = run_min;
        hi = run_max;
        // flat set scales as 0..1
        if (lo == hi) begin
            lo = 0;
            hi = 1;
        end
        span_d = hi - lo;
        span_w = (cur_width > 2 * cur_pad) ? cur_width - 2 * cur_pad : 0;
        span_h = (cur_height > 2 * cur_pad) ? cur_height - 2 * cur_pad : 0;
        last_slot = 0;
        for (int i = 0; i < held_count; i++) begin
            if (held_ok[i]) last_slot = i;
        end
        for (int i = 0; i < held_count; i++) begin
            if (!held_ok[i]) continue;
            x = (held_count > 1) ? cur_pad + span_w * i / (held_count - 1) : cur_pad;
            num = (cur_height - cur_pad) * span_d - span_h * (longint'(held_value[i]) - lo);
            y = (num < 0) ? 0 : num / span_d;
            pt.x    = to_pixel(x);
            pt.y    = to_pixel(y);
            pt.last = (i == last_slot);
            point_q.push_back(pt);
        end
        restart_set();
    endtask

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;

    always @(posedge aclk) begin
        sample_item_t nxt;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                map_item(s_sample_value, s_sample_valid, s_end_of_set);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    nxt = pending_q.pop_front();
                    s_valid        <= 1'b1;
                    s_sample_value <= nxt.value;
                    s_sample_valid <= nxt.ok;
                    s_end_of_set   <= nxt.eos;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating ready pattern, plus a long hold-off on request
    int          hold_left;
    int          pat_age;
    logic [15:0] ready_pat;

    always @(posedge aclk) begin
        point_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            pat_age   = 0;
            ready_pat = '1;
        end else begin
            if (m_valid && m_ready) begin
                points_seen++;
                if (point_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point %0d not expected: x=%0d y=%0d last=%0b",
                                 points_seen, m_point_x, m_point_y, m_last_point);
                end else begin
                    want = point_q.pop_front();
                    if (m_point_x !== want.x || m_point_y !== want.y ||
                        m_last_point !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"point %0d mismatch: exp x=%0d y=%0d last=%0b, ",
                                      "got x=%0d y=%0d last=%0b"}, points_seen,
                                     want.x, want.y, want.last,
                                     m_point_x, m_point_y, m_last_point);
                    end
                end
            end
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                hold_left  = LONG_HOLD;
            end
            if (pat_age == 0) begin
                ready_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
                pat_age   = 64;
            end
            pat_age--;
            ready_pat = {ready_pat[0], ready_pat[15:1]};
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ready_pat[0];
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("[autoscale_plot_point_mapper_core] ERROR");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic signed [SMP_W-1:0] value, input logic ok,
                              input logic eos);
        sample_item_t it;
        it.value = value;
        it.ok    = ok;
        it.eos   = eos;
        pending_q.push_back(it);
        items_queued++;
    endtask

    task automatic queue_set(input int len, input set_kind_t kind, input int invalid_pct);
        int                      base;
        logic signed [SMP_W-1:0] flat_value;
        logic signed [SMP_W-1:0] v;
        logic                    ok;
        base       = int'($urandom_range(0, 65520)) - 32768;
        flat_value = SMP_W'($urandom);
        for (int k = 0; k < len; k++) begin
            case (kind)
                SET_WIDE:   v = SMP_W'($urandom);
                SET_NARROW: v = SMP_W'(base + int'($urandom_range(0, 15)));
                SET_FLAT:   v = flat_value;
                default:    v = SMP_W'($urandom);
            endcase
            ok = (kind != SET_BLANK) && ($urandom_range(0, 99) >= invalid_pct);
            queue_item(v, ok, k == len - 1);
        end
    endtask

    task automatic queue_random(input bit heavy);
        int        added;
        int        len;
        int        pick;
        bit        big_done;
        set_kind_t kind;
        added    = 0;
        big_done = 1'b0;
        while (added < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            kind = ($urandom_range(0, 1) == 0) ? SET_WIDE : SET_NARROW;
            if (heavy) begin
                len = $urandom_range(20, 40);
                queue_set(len, SET_WIDE, 10);
            end else if (pick < 45) begin
                len = $urandom_range(1, 8);
                queue_set(len, kind, 20);
            end else if (pick < 65) begin
                len = $urandom_range(9, 24);
                queue_set(len, kind, 20);
            end else if (pick < 75) begin
                len = $urandom_range(1, 6);
                queue_set(len, SET_FLAT, 30);
            end else if (pick < 85 || big_done) begin
                len = $urandom_range(1, 4);
                queue_set(len, SET_BLANK, 0);
            end else begin
                // set of 63 to 70 items: one short of full, full, or past the last slot
                len = $urandom_range(63, 70);
                queue_set(len, SET_NARROW, 60);
                big_done = 1'b1;
            end
            added += len;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PLOT_WIDTH:   cur_width  = data;
            REG_PLOT_HEIGHT:  cur_height = data;
            REG_EDGE_PADDING: cur_pad    = data[PAD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_plot(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] p);
        write_reg(REG_PLOT_WIDTH, w);
        write_reg(REG_PLOT_HEIGHT, h);
        write_reg(REG_EDGE_PADDING, p);
    endtask

    // wait until every item is taken and every point has come out
    task automatic drain();
        while (items_taken != items_queued) @(posedge aclk);
        while (point_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        restart_set();
        cur_width  = PLOT_WIDTH_RST;
        cur_height = PLOT_HEIGHT_RST;
        cur_pad    = EDGE_PADDING_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // single-slot set, flat
        queue_item(16'sd1234, 1'b1, 1'b1);
        // field extremes with a skipped slot
        queue_item(-16'sd32768, 1'b1, 1'b0);
        queue_item(16'sd0, 1'b0, 1'b0);
        queue_item(16'sd32767, 1'b1, 1'b0);
        queue_item(-16'sd1, 1'b1, 1'b0);
        queue_item(16'sd1, 1'b1, 1'b1);
        // flat negative set, y saturates high
        queue_item(-16'sd32768, 1'b1, 1'b0);
        queue_item(-16'sd32768, 1'b1, 1'b1);
        // no valid samples
        queue_item(16'sd5, 1'b0, 1'b0);
        queue_item(-16'sd5, 1'b0, 1'b1);
        // closing item itself skipped
        queue_item(16'sd100, 1'b1, 1'b0);
        queue_item(16'sd200, 1'b1, 1'b0);
        queue_item(16'sd300, 1'b0, 1'b1);
        // flat positive set with a gap
        queue_item(16'sd7, 1'b1, 1'b0);
        queue_item(16'sd7, 1'b1, 1'b0);
        queue_item(16'sd7, 1'b0, 1'b0);
        queue_item(16'sd7, 1'b1, 1'b1);
        // lone closing item
        queue_item(16'sd0, 1'b0, 1'b1);
        drain();

        for (int step_no = 1; step_no <= 6; step_no++) begin
            case (step_no)
                1: begin
                    set_plot(12'd0, 12'd0, 12'd0);
                    write_reg(REG_UNMAPPED, 12'hABC);
                end
                2: set_plot(12'd4095, 12'd4095, 12'd255);
                3: set_plot(12'd4095, 12'd4095, 12'd0);
                // padding larger than the area
                4: set_plot(12'd100, 12'd60, 12'd255);
                default: set_plot(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
            endcase
            // long receiver hold while the sender keeps offering
            if (step_no == 2) holds_asked++;
            queue_random(step_no == 2);
            drain();
        end

        if (mismatches == 0 && point_q.size() == 0) begin
            $display("[autoscale_plot_point_mapper_core] OK");
        end else begin
            $display("%0d mismatches, %0d points still expected", mismatches, point_q.size());
            $display("[autoscale_plot_point_mapper_core] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
src/apm_pkg.sv
src/apm_front.sv
src/apm_queue.sv
src/apm_div.sv
src/apm_back.sv
src/autoscale_plot_point_mapper_core.sv
src/apm_checker.sv
sim/tb_autoscale_plot_point_mapper_core.sv
